[hw/rtl/tse_pkg.sv]
// Shared types, field codes and protocol constants for the server-name extractor.
package tse_pkg;

    // Result codes
    localparam logic [2:0] OC_NAME_BYTE     = 3'd0;
    localparam logic [2:0] OC_NOT_HANDSHAKE = 3'd1;
    localparam logic [2:0] OC_NOT_HELLO     = 3'd2;
    localparam logic [2:0] OC_NO_NAME       = 3'd3;
    localparam logic [2:0] OC_EMPTY_NAME    = 3'd4;
    localparam logic [2:0] OC_NAME_TRUNC    = 3'd5;

    // Protocol values
    localparam logic [7:0]  CT_HANDSHAKE    = 8'd22;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [15:0] EXT_SERVER_NAME = 16'd0;

    // Fixed skip lengths
    localparam logic [15:0] RECORD_HDR_SKIP = 16'd4;
    localparam logic [15:0] FIXED_SKIP      = 16'd37;
    localparam logic [15:0] NAME_HDR_SKIP   = 16'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] name_byte;
        logic       last;
    } out_item_t;

    // Parser result handed to the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

endpackage

[hw/rtl/tse_in_stage.sv]
// Input register: holds one accepted request until the parser consumes it.
module tse_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tse_pkg::in_item_t item,
    input  logic              advance,
    output logic              valid,
    output tse_pkg::in_item_t data
);

    logic              valid_reg;
    logic              valid_next;
    tse_pkg::in_item_t data_reg;

    // Take a new request whenever the held one is empty or leaving
    assign item_stall = valid_reg && !advance;
    assign valid_next = item_stall ? valid_reg : item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            data_reg <= item;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[hw/rtl/tse_parser.sv]
// Record parser: phase tracking, length counting and result decision per byte.
module tse_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tse_pkg::in_item_t data,
    output tse_pkg::res_t     res
);

    typedef enum logic [3:0] {
        PH_CTYPE   = 4'd0,
        PH_RECHDR  = 4'd1,
        PH_HTYPE   = 4'd2,
        PH_FIXED   = 4'd3,
        PH_SIDLEN  = 4'd4,
        PH_SID     = 4'd5,
        PH_CSLEN   = 4'd6,
        PH_CS      = 4'd7,
        PH_CMLEN   = 4'd8,
        PH_CM      = 4'd9,
        PH_EXTTOT  = 4'd10,
        PH_EXTHDR  = 4'd11,
        PH_EXTSKIP = 4'd12,
        PH_NAMEHDR = 4'd13,
        PH_NAMELEN = 4'd14,
        PH_NAME    = 4'd15
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic        is_name_reg, is_name_next;
    logic        discard_reg, discard_next;

    logic [7:0]  b;
    logic        pkt_end;
    logic [15:0] acc_shift;
    logic [15:0] count_dec;
    logic [1:0]  idx_inc;
    logic        have;
    logic        last;
    logic [2:0]  oc;
    logic [7:0]  nb;

    assign b         = data.data_byte;
    assign pkt_end   = data.packet_end;
    assign acc_shift = {acc_reg[7:0], b};
    assign count_dec = count_reg - 16'd1;
    assign idx_inc   = idx_reg + 2'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        is_name_next = is_name_reg;
        discard_next = discard_reg;
        have         = 1'b0;
        last         = 1'b0;
        oc           = tse_pkg::OC_NAME_BYTE;
        nb           = 8'd0;

        if (discard_reg)
        begin
            if (pkt_end)
            begin
                discard_next = 1'b0;
                phase_next   = PH_CTYPE;
                count_next   = 16'd0;
                acc_next     = 16'd0;
                idx_next     = 2'd0;
                is_name_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CTYPE:
                begin
                    if (b != tse_pkg::CT_HANDSHAKE)
                    begin
                        have = 1'b1;
                        last = 1'b1;
                        oc   = tse_pkg::OC_NOT_HANDSHAKE;
                    end
                    else
                    begin
                        count_next = tse_pkg::RECORD_HDR_SKIP;
                        phase_next = PH_RECHDR;
                    end
                end
                PH_HTYPE:
                begin
                    if (b != tse_pkg::HS_CLIENT_HELLO)
                    begin
                        have = 1'b1;
                        last = 1'b1;
                        oc   = tse_pkg::OC_NOT_HELLO;
                    end
                    else
                    begin
                        count_next = tse_pkg::FIXED_SKIP;
                        phase_next = PH_FIXED;
                    end
                end
                PH_RECHDR, PH_FIXED, PH_SID, PH_CS, PH_CM, PH_EXTSKIP, PH_NAMEHDR:
                begin
                    count_next = count_dec;
                    if (count_dec == 16'd0)
                    begin
                        phase_next = (phase_reg == PH_EXTSKIP) ? PH_EXTHDR
                                                               : phase_t'(phase_reg + 4'd1);
                    end
                end
                PH_SIDLEN:
                begin
                    count_next = {8'd0, b};
                    phase_next = (b == 8'd0) ? PH_CSLEN : PH_SID;
                end
                PH_CMLEN:
                begin
                    count_next = {8'd0, b};
                    phase_next = (b == 8'd0) ? PH_EXTTOT : PH_CM;
                end
                PH_CSLEN, PH_EXTTOT, PH_NAMELEN:
                begin
                    acc_next = acc_shift;
                    idx_next = idx_inc;
                    if (idx_inc == 2'd2)
                    begin
                        idx_next = 2'd0;
                        acc_next = 16'd0;
                        if (phase_reg == PH_CSLEN)
                        begin
                            count_next = acc_shift;
                            phase_next = (acc_shift == 16'd0) ? PH_CMLEN : PH_CS;
                        end
                        else if (phase_reg == PH_EXTTOT)
                        begin
                            phase_next = PH_EXTHDR;
                        end
                        else if (acc_shift == 16'd0)
                        begin
                            have = 1'b1;
                            last = 1'b1;
                            oc   = tse_pkg::OC_EMPTY_NAME;
                        end
                        else
                        begin
                            count_next = acc_shift;
                            phase_next = PH_NAME;
                        end
                    end
                end
                PH_EXTHDR:
                begin
                    acc_next = acc_shift;
                    idx_next = idx_inc;
                    // Type word completes on the second byte, length on the fourth
                    if (idx_inc == 2'd2)
                    begin
                        is_name_next = (acc_shift == tse_pkg::EXT_SERVER_NAME);
                        acc_next     = 16'd0;
                    end
                    else if (idx_inc == 2'd0)
                    begin
                        acc_next = 16'd0;
                        if (is_name_reg)
                        begin
                            count_next = tse_pkg::NAME_HDR_SKIP;
                            phase_next = PH_NAMEHDR;
                        end
                        else
                        begin
                            count_next = acc_shift;
                            phase_next = (acc_shift == 16'd0) ? PH_EXTHDR : PH_EXTSKIP;
                        end
                    end
                end
                PH_NAME:
                begin
                    have       = 1'b1;
                    nb         = b;
                    count_next = count_dec;
                    if (count_dec == 16'd0)
                    begin
                        last = 1'b1;
                    end
                    else if (pkt_end)
                    begin
                        oc   = tse_pkg::OC_NAME_TRUNC;
                        last = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Packet ran out before a decision
            if (!have && pkt_end)
            begin
                have = 1'b1;
                last = 1'b1;
                nb   = 8'd0;
                oc   = (phase_next >= PH_NAMEHDR) ? tse_pkg::OC_NAME_TRUNC
                                                  : tse_pkg::OC_NO_NAME;
            end

            // Final result: restart, drop the rest of the packet if any
            if (have && last)
            begin
                phase_next   = PH_CTYPE;
                count_next   = 16'd0;
                acc_next     = 16'd0;
                idx_next     = 2'd0;
                is_name_next = 1'b0;
                discard_next = !pkt_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CTYPE;
            count_reg   <= 16'd0;
            acc_reg     <= 16'd0;
            idx_reg     <= 2'd0;
            is_name_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            is_name_reg <= is_name_next;
            discard_reg <= discard_next;
        end
    end

    assign res.valid          = fire && have;
    assign res.item.outcome   = oc;
    assign res.item.name_byte = nb;
    assign res.item.last      = last;

endmodule

[hw/rtl/tse_out_stage.sv]
// Result register: holds one result until the downstream side takes it.
module tse_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  tse_pkg::res_t      res,
    output logic               advance,
    output logic               result_valid,
    input  logic               result_stall,
    output tse_pkg::out_item_t result
);

    logic               valid_reg;
    logic               valid_next;
    tse_pkg::out_item_t item_reg;

    // Register is free when empty or being drained this cycle
    assign advance    = !valid_reg || !result_stall;
    assign valid_next = advance ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign result_valid = valid_reg;
    assign result       = item_reg;

endmodule

[hw/rtl/tls_sni_extractor_top.sv]
// Top level of the TLS ClientHello server-name extractor.
//
// Feed the bytes of a TLS record one per request on the item channel, with
// packet_end set on the final byte of the packet. The block checks for a
// handshake record carrying a ClientHello, skips the record header, the fixed
// hello fields, session id, cipher suite and compression lists, then walks the
// extensions. When it finds server_name it returns one result per name byte
// (outcome 0, last on the final name byte). Otherwise it returns one reject
// outcome with last set: not handshake, not ClientHello, empty name, no name
// extension (packet ended first) or name truncated (packet ended inside the
// name). After a final result, the remaining bytes of that packet give nothing.
// Many bytes give no result at all. Throughput is one byte per clock cycle
// while the result side is not stalled: the per-byte work is a phase update
// and a counter decrement in one pass of logic between an input register and
// a result register, where the result of each accepted byte is registered.
// While a result is held under stall, one more request is still taken into
// the input register.
module tls_sni_extractor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  tse_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output tse_pkg::out_item_t result
);

    logic              advance;
    logic              in_valid;
    tse_pkg::in_item_t in_data;
    tse_pkg::res_t     res;

    // Input register: decouples upstream from a stalled result
    tse_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .valid      (in_valid),
        .data       (in_data)
    );

    // Parser: consume the held byte whenever the result register can take it
    tse_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (in_valid && advance),
        .data  (in_data),
        .res   (res)
    );

    // Result register toward downstream
    tse_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[tb/sv/tls_sni_extractor_top_tb.sv]
// Self-checking testbench for the TLS ClientHello server-name extractor top level.
module tls_sni_extractor_top_tb;

    // Parser phases of the server-name predictor, in stream order.
    // The order matters: every phase at or after S_SNIHDR counts as inside the name.
    typedef enum logic [3:0] {
        S_CONTENT, S_RECHDR, S_HSTYPE, S_FIXED, S_SIDLEN, S_SID, S_CSLEN, S_CS,
        S_CMLEN, S_CM, S_EXTLEN, S_EXTHDR, S_EXTBODY, S_SNIHDR, S_SNILEN, S_SNI
    } sni_phase_t;

    // Kinds of packet that the random part builds
    typedef enum int {
        SHP_FULL, SHP_CUT, SHP_CUT_NAME, SHP_NO_SNI, SHP_BAD_HDR, SHP_NOISE
    } pkt_shape_t;

    // One row of the directed table: the request, and where the outcome can be
    // read off at a glance, the result it must give (or that it gives none).
    typedef struct packed {
        tse_pkg::in_item_t  req;
        logic               typed;
        logic               yields;
        tse_pkg::out_item_t want;
    } dir_row_t;

    localparam int ITEMS_TARGET = 1250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    tse_pkg::in_item_t  item         = '0;
    logic               result_stall = 1'b0;
    logic               item_stall;
    logic               result_valid;
    tse_pkg::out_item_t result;

    // Predictor state
    sni_phase_t  ps;
    logic [16:0] cdown;
    logic [15:0] facc;
    logic [1:0]  fidx;
    bit          ext_is_sni;
    bit          drain_pkt;

    tse_pkg::out_item_t sni_results_due[$];
    dir_row_t           dir_rows[$];
    logic [7:0]         pkt[$];
    int                 sni_at;
    int                 name_last;

    int                 err_cnt;
    int                 sent_cnt;
    int                 parsed_cnt;
    int                 checked_cnt;
    int                 pkt_cnt;
    int                 burst_left;
    int                 quiet_cycles;
    int                 oc_seen[0:7];
    int                 stall_mode;
    int                 stall_left;
    int                 stall_tick;
    tse_pkg::out_item_t due;

    tls_sni_extractor_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Server-name predictor: one call per accepted request
    // ------------------------------------------------------------------

    function automatic void parse_restart();
        ps         = S_CONTENT;
        cdown      = '0;
        facc       = '0;
        fidx       = '0;
        ext_is_sni = 1'b0;
    endfunction

    // A length is known: skip that many bytes, or go straight on when it is zero.
    function automatic void load_skip(input logic [15:0] count, input sni_phase_t skip_to,
                                      input sni_phase_t after);
        cdown = {1'b0, count};
        ps    = (count == 16'd0) ? after : skip_to;
    endfunction

    function automatic void shift_field(input logic [7:0] b);
        facc = {facc[7:0], b};
        fidx = fidx + 2'd1;
    endfunction

    function automatic bit sni_parse_byte(input tse_pkg::in_item_t req,
                                          output tse_pkg::out_item_t res);
        logic [7:0]  b;
        logic [15:0] v;
        bit          have;
        b    = req.data_byte;
        have = 1'b0;
        res  = '0;
        // After a final result, drop everything up to and including packet_end.
        if (drain_pkt)
        begin
            if (req.packet_end)
            begin
                drain_pkt = 1'b0;
                parse_restart();
            end
            return 1'b0;
        end
        parsed_cnt++;
        case (ps)
            S_CONTENT:
            begin
                if (b != tse_pkg::CT_HANDSHAKE)
                begin
                    have        = 1'b1;
                    res.outcome = tse_pkg::OC_NOT_HANDSHAKE;
                    res.last    = 1'b1;
                end
                else
                begin
                    load_skip(tse_pkg::RECORD_HDR_SKIP, S_RECHDR, S_HSTYPE);
                end
            end
            S_HSTYPE:
            begin
                if (b != tse_pkg::HS_CLIENT_HELLO)
                begin
                    have        = 1'b1;
                    res.outcome = tse_pkg::OC_NOT_HELLO;
                    res.last    = 1'b1;
                end
                else
                begin
                    load_skip(tse_pkg::FIXED_SKIP, S_FIXED, S_SIDLEN);
                end
            end
            S_RECHDR, S_FIXED, S_SID, S_CS, S_CM, S_EXTBODY, S_SNIHDR:
            begin
                cdown = cdown - 17'd1;
                if (cdown == 17'd0)
                begin
                    ps = (ps == S_EXTBODY) ? S_EXTHDR : sni_phase_t'(ps + 4'd1);
                end
            end
            S_SIDLEN:
            begin
                load_skip({8'h00, b}, S_SID, S_CSLEN);
            end
            S_CMLEN:
            begin
                load_skip({8'h00, b}, S_CM, S_EXTLEN);
            end
            S_CSLEN, S_EXTLEN, S_SNILEN:
            begin
                shift_field(b);
                if (fidx == 2'd2)
                begin
                    v    = facc;
                    fidx = '0;
                    facc = '0;
                    if (ps == S_CSLEN)
                    begin
                        load_skip(v, S_CS, S_CMLEN);
                    end
                    else if (ps == S_EXTLEN)
                    begin
                        ps = S_EXTHDR;
                    end
                    else if (v == 16'd0)
                    begin
                        have        = 1'b1;
                        res.outcome = tse_pkg::OC_EMPTY_NAME;
                        res.last    = 1'b1;
                    end
                    else
                    begin
                        cdown = {1'b0, v};
                        ps    = S_SNI;
                    end
                end
            end
            S_EXTHDR:
            begin
                // Type in bytes one and two, length in bytes three and four.
                shift_field(b);
                if (fidx == 2'd2)
                begin
                    ext_is_sni = (facc == tse_pkg::EXT_SERVER_NAME);
                    facc       = '0;
                end
                else if (fidx == 2'd0)
                begin
                    v    = facc;
                    facc = '0;
                    if (ext_is_sni)
                    begin
                        load_skip(tse_pkg::NAME_HDR_SKIP, S_SNIHDR, S_SNILEN);
                    end
                    else
                    begin
                        load_skip(v, S_EXTBODY, S_EXTHDR);
                    end
                end
            end
            default:
            begin
                have          = 1'b1;
                res.name_byte = b;
                cdown         = cdown - 17'd1;
                if (cdown == 17'd0)
                begin
                    res.outcome = tse_pkg::OC_NAME_BYTE;
                    res.last    = 1'b1;
                end
                else if (req.packet_end)
                begin
                    res.outcome = tse_pkg::OC_NAME_TRUNC;
                    res.last    = 1'b1;
                end
                else
                begin
                    res.outcome = tse_pkg::OC_NAME_BYTE;
                end
            end
        endcase
        // Packet ran out before a verdict: report where it stopped.
        if (!have && req.packet_end)
        begin
            have          = 1'b1;
            res.last      = 1'b1;
            res.name_byte = 8'h00;
            res.outcome   = (ps >= S_SNIHDR) ? tse_pkg::OC_NAME_TRUNC : tse_pkg::OC_NO_NAME;
        end
        if (have && res.last)
        begin
            parse_restart();
            drain_pkt = !req.packet_end;
        end
        return have;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic void row_typed(input logic [7:0] d, input bit fin, input bit yields,
                                      input logic [2:0] oc);
        dir_row_t r;
        r.req.data_byte  = d;
        r.req.packet_end = fin;
        r.typed          = 1'b1;
        r.yields         = yields;
        r.want.outcome   = oc;
        r.want.name_byte = 8'h00;
        r.want.last      = 1'b1;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_open(input logic [7:0] d, input bit fin);
        dir_row_t r;
        r                = '0;
        r.req.data_byte  = d;
        r.req.packet_end = fin;
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Packet builder for the random part
    // ------------------------------------------------------------------

    function automatic void put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_junk(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // Append one extension that is not server_name.
    function automatic void put_ext();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        put16(16'($urandom_range(1, 65535)));
        put16(16'(n));
        put_junk(n);
    endfunction

    task automatic build_packet(input pkt_shape_t shape);
        int sid_n;
        int cs_n;
        int cm_n;
        int name_n;
        int v;
        pkt.delete();
        sni_at    = -1;
        name_last = -1;
        if (shape == SHP_NOISE)
        begin
            put_junk($urandom_range(1, 12));
            return;
        end
        pkt.push_back(tse_pkg::CT_HANDSHAKE);
        put_junk(4);
        pkt.push_back(tse_pkg::HS_CLIENT_HELLO);
        put_junk(37);
        sid_n = $urandom_range(0, 32);
        pkt.push_back(8'(sid_n));
        put_junk(sid_n);
        // Mostly short cipher lists; now and then one long enough to use the high byte.
        cs_n = ($urandom_range(0, 15) == 0) ? 2 * $urandom_range(128, 300)
                                            : 2 * $urandom_range(0, 8);
        put16(16'(cs_n));
        put_junk(cs_n);
        cm_n = $urandom_range(0, 3);
        pkt.push_back(8'(cm_n));
        put_junk(cm_n);
        put_junk(2);
        repeat ($urandom_range(0, 2)) put_ext();
        if (shape != SHP_NO_SNI)
        begin
            sni_at = pkt.size();
            put16(tse_pkg::EXT_SERVER_NAME);
            put_junk(5);
            v      = $urandom_range(0, 15);
            name_n = (v < 2) ? 0 : (v == 2) ? $urandom_range(200, 300) : $urandom_range(1, 24);
            put16(16'(name_n));
            put_junk(name_n);
            name_last = pkt.size() - 1;
        end
        // Trailing extensions leave a tail after the verdict.
        if ($urandom_range(0, 1) == 1)
        begin
            repeat ($urandom_range(1, 2)) put_ext();
        end
        if (shape == SHP_BAD_HDR)
        begin
            v = $urandom_range(0, 254);
            if ($urandom_range(0, 1) == 1)
            begin
                pkt[0] = (v >= tse_pkg::CT_HANDSHAKE) ? 8'(v + 1) : 8'(v);
            end
            else
            begin
                pkt[5] = (v >= tse_pkg::HS_CLIENT_HELLO) ? 8'(v + 1) : 8'(v);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Hold valid low between bursts; each burst has a random length.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(0, 3);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                item       <= tse_pkg::in_item_t'(9'($urandom_range(0, 511)));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one request, hold it until accepted, then record what it should give.
    task automatic send_req(input tse_pkg::in_item_t req, input bit typed, input bit yields,
                            input tse_pkg::out_item_t want);
        tse_pkg::out_item_t calc;
        bit                 got;
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        got = sni_parse_byte(req, calc);
        if (typed)
        begin
            got  = yields;
            calc = want;
        end
        if (got)
        begin
            sni_results_due.push_back(calc);
        end
        sent_cnt++;
    endtask

    // Pause the sender until every expected result has come back.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sni_results_due.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver back-pressure: switch among a few stall patterns
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        else
        begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ((stall_tick % 2) == 1);
            default: result_stall <= ((stall_tick % 8) < 6);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one due
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            checked_cnt++;
            oc_seen[result.outcome]++;
            if (sni_results_due.size() == 0)
            begin
                $display("%0t: result with none due: outcome %0d name_byte %02h last %0b",
                         $time, result.outcome, result.name_byte, result.last);
                err_cnt++;
            end
            else
            begin
                due = sni_results_due.pop_front();
                if (result.outcome !== due.outcome)
                begin
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, due.outcome, result.outcome);
                    err_cnt++;
                end
                if (result.name_byte !== due.name_byte)
                begin
                    $display("%0t: name_byte expected %02h actual %02h",
                             $time, due.name_byte, result.name_byte);
                    err_cnt++;
                end
                if (result.last !== due.last)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, due.last, result.last);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles, %0d results still due",
                     $time, QUIET_LIMIT, sni_results_due.size());
            $display("tls_sni_extractor_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int                i;
        int                keep;
        int                base;
        int                r;
        pkt_shape_t        shape;
        tse_pkg::in_item_t req;

        parse_restart();
        drain_pkt = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reject on a wrong content type, then drop the rest.
        row_typed(8'h00, 1'b0, 1'b1, tse_pkg::OC_NOT_HANDSHAKE);
        row_typed(8'hFF, 1'b0, 1'b0, tse_pkg::OC_NAME_BYTE);
        row_typed(tse_pkg::CT_HANDSHAKE, 1'b1, 1'b0, tse_pkg::OC_NAME_BYTE);
        // A reject wins over packet_end on the same byte.
        row_typed(8'hFF, 1'b1, 1'b1, tse_pkg::OC_NOT_HANDSHAKE);
        // Packet ends right after a good content type.
        row_typed(tse_pkg::CT_HANDSHAKE, 1'b1, 1'b1, tse_pkg::OC_NO_NAME);
        // Handshake record that is not a ClientHello, with a tail to drop.
        row_open(tse_pkg::CT_HANDSHAKE, 1'b0);
        row_open(8'h03, 1'b0);
        row_open(8'h01, 1'b0);
        row_open(8'h00, 1'b0);
        row_open(8'hFF, 1'b0);
        row_typed(8'h00, 1'b0, 1'b1, tse_pkg::OC_NOT_HELLO);
        row_typed(8'hAA, 1'b1, 1'b0, tse_pkg::OC_NAME_BYTE);
        // Wrong handshake type on the final byte.
        row_open(tse_pkg::CT_HANDSHAKE, 1'b0);
        row_open(8'h03, 1'b0);
        row_open(8'h03, 1'b0);
        row_open(8'h01, 1'b0);
        row_open(8'h00, 1'b0);
        row_typed(8'hFF, 1'b1, 1'b1, tse_pkg::OC_NOT_HELLO);
        // ClientHello that ends inside the fixed fields.
        row_open(tse_pkg::CT_HANDSHAKE, 1'b0);
        row_open(8'h03, 1'b0);
        row_open(8'h01, 1'b0);
        row_open(8'h02, 1'b0);
        row_open(8'h00, 1'b0);
        row_open(tse_pkg::HS_CLIENT_HELLO, 1'b0);
        row_typed(8'h55, 1'b1, 1'b1, tse_pkg::OC_NO_NAME);

        foreach (dir_rows[k])
        begin
            pace();
            send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].yields, dir_rows[k].want);
        end
        hold_until_drained();

        // Random part: mostly well-formed hellos with random content, cut in
        // various places, plus broken headers and plain noise. The first packets
        // step through every shape once.
        base = sent_cnt;
        while (sent_cnt - base < ITEMS_TARGET)
        begin
            if (pkt_cnt <= SHP_NOISE)
            begin
                shape = pkt_shape_t'(pkt_cnt);
            end
            else
            begin
                r = $urandom_range(0, 15);
                shape = (r < 7)  ? SHP_FULL :
                        (r < 9)  ? SHP_CUT :
                        (r < 11) ? SHP_CUT_NAME :
                        (r < 12) ? SHP_NO_SNI :
                        (r < 14) ? SHP_BAD_HDR : SHP_NOISE;
            end
            build_packet(shape);
            case (shape)
                SHP_CUT:      keep = $urandom_range(1, pkt.size());
                SHP_CUT_NAME: keep = $urandom_range(sni_at + 3, name_last - 1) + 1;
                default:      keep = pkt.size();
            endcase
            for (i = 0; i < keep; i++)
            begin
                req.data_byte  = pkt[i];
                req.packet_end = (i == keep - 1);
                pace();
                send_req(req, 1'b0, 1'b0, '0);
            end
            pkt_cnt++;
            if (pkt_cnt % 6 == 0)
            begin
                hold_until_drained();
            end
        end

        // Wind down: wait for every result due, then wait out a tail for strays.
        item_valid <= 1'b0;
        while (sni_results_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d table rows, %0d packets); %0d bytes parsed, %0d results",
                 sent_cnt, dir_rows.size(), pkt_cnt, parsed_cnt, checked_cnt);
        $display("Outcomes: name %0d, not handshake %0d, not hello %0d, no name %0d, %s %0d, %s %0d",
                 oc_seen[tse_pkg::OC_NAME_BYTE], oc_seen[tse_pkg::OC_NOT_HANDSHAKE],
                 oc_seen[tse_pkg::OC_NOT_HELLO], oc_seen[tse_pkg::OC_NO_NAME],
                 "empty", oc_seen[tse_pkg::OC_EMPTY_NAME],
                 "truncated", oc_seen[tse_pkg::OC_NAME_TRUNC]);
        if (err_cnt == 0)
        begin
            $display("tls_sni_extractor_top regression: pass");
        end
        else
        begin
            $display("tls_sni_extractor_top regression: fail");
        end
        $finish;
    end

endmodule
